// ----- rtl/framebuffer_pixel_format_converter_core_assert.svh -----
// Assertion macros shared by the RTL.
// FBPFC_ASSERT checks a property under the given clock and active-low reset.
// FBPFC_ASSERT_IMP checks that an antecedent implies a consequent in the following cycle.
`ifndef FRAMEBUFFER_PIXEL_FORMAT_CONVERTER_CORE_ASSERT_SVH
`define FRAMEBUFFER_PIXEL_FORMAT_CONVERTER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define FBPFC_ASSERT(lbl, clock, resetn, prop, msg) \
    lbl: assert property (@(posedge clock) disable iff (!resetn) prop) else $error(msg);
`define FBPFC_ASSERT_IMP(lbl, clock, resetn, ante, cons, msg) \
    lbl: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FBPFC_ASSERT(lbl, clock, resetn, prop, msg)
`define FBPFC_ASSERT_IMP(lbl, clock, resetn, ante, cons, msg)
`endif

`endif

// ----- rtl/fbpfc_pkg.sv -----
`timescale 1ns / 1ps
package fbpfc_pkg;

    localparam int PaletteEntriesDefault = 256;
    localparam int PixelWidth = 24;
    localparam int SrcWidth = 32;
    localparam int ColorWidth = 24;
    localparam int IndexWidth = 8;
    localparam int CfgIndexWidth = 2;
    localparam int CfgDataWidth = 3;

    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_SOURCE_DEPTH = 2'd0,
        CFG_RGB_ORDER    = 2'd1,
        CFG_DEST_FORMAT  = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        SRC_PAL8   = 3'd0,
        SRC_RGB565 = 3'd1,
        SRC_RGB24  = 3'd2,
        SRC_RGB32  = 3'd3,
        SRC_NONE   = 3'd4
    } src_depth_t;

    typedef enum logic [2:0] {
        DST_8BPP  = 3'd0,
        DST_15BPP = 3'd1,
        DST_16BPP = 3'd2,
        DST_24BPP = 3'd3,
        DST_32BPP = 3'd4
    } dest_format_t;

    typedef enum logic {
        OP_CONVERT = 1'b0,
        OP_LOAD    = 1'b1
    } op_t;

    typedef struct packed {
        src_depth_t   source_depth;
        logic         rgb_order;
        dest_format_t dest_format;
    } cfg_t;

endpackage

// ----- rtl/fbpfc_ifaces.sv -----
`timescale 1ns / 1ps
interface fbpfc_in_if
    import fbpfc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [SrcWidth-1:0]   src_pixel;
    logic [IndexWidth-1:0] palette_index;
    logic [ColorWidth-1:0] palette_color;

    modport source (output valid, op, src_pixel, palette_index, palette_color, input ready);
    modport sink (input valid, op, src_pixel, palette_index, palette_color, output ready);
endinterface

interface fbpfc_out_if
    import fbpfc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [PixelWidth-1:0] out_pixel;

    modport source (output valid, out_pixel, input ready);
    modport sink (input valid, out_pixel, output ready);
endinterface

// ----- rtl/framebuffer_pixel_format_converter_core.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Words                                           Notes
// pix_in    in   op, src_pixel, palette_index, palette_color     convert or palette load
// pix_out   out  out_pixel                                       one word per convert with a known format
// cfg_*     in   cfg_index, cfg_wdata (write enable cfg_we)      source_depth, rgb_order,
//                                                                dest_format
//
// One word accepted per clock while the output is not stalled. A convert word passes
// through the synchronous palette read in the palette stage, then expand/swap/pack into
// the output register. A load word writes the palette at its accept edge and gives no
// result; so does a convert with an unknown destination format.
// Reset clears the pipeline valid bits and the configuration (source RGB565, RGB order,
// 32 bpp); palette contents stay undefined until loaded.
// A stalled output holds the output register, then the palette stage, then pix_in.ready.
`include "framebuffer_pixel_format_converter_core_assert.svh"
module framebuffer_pixel_format_converter_core
    import fbpfc_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PaletteEntriesDefault
) (
    input  logic                     clk,
    input  logic                     rst_n,
    fbpfc_in_if.sink                 pix_in,
    fbpfc_out_if.source              pix_out,
    input  logic                     cfg_we,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_wdata
);

    localparam int AddrWidth = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    // configuration registers
    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SOURCE_DEPTH: cfg_next.source_depth = src_depth_t'(cfg_wdata);
                CFG_RGB_ORDER:    cfg_next.rgb_order = cfg_wdata[0];
                CFG_DEST_FORMAT:  cfg_next.dest_format = dest_format_t'(cfg_wdata);
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_depth <= SRC_RGB565;
            cfg_reg.rgb_order    <= 1'b1;
            cfg_reg.dest_format  <= DST_32BPP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // handshake and stage control
    logic in_accept;
    logic is_load;
    logic dest_ok;
    logic idx_hit;
    logic pal_adv;

    logic                  pal_valid_reg;
    logic                  pal_valid_next;
    logic                  pal_hit_reg;
    logic [23:0]           pal_src_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [PixelWidth-1:0] out_pixel_reg;
    logic [PixelWidth-1:0] conv_pixel;
    logic [ColorWidth-1:0] pal_rd_data;

    // advance the palette stage when the output register is free or being drained
    assign pal_adv = !out_valid_reg || pix_out.ready;
    assign pix_in.ready = !pal_valid_reg || pal_adv;
    assign in_accept = pix_in.valid && pix_in.ready;
    assign is_load = (op_t'(pix_in.op) == OP_LOAD);
    assign dest_ok = (cfg_reg.dest_format <= DST_32BPP);

    // drop indexes beyond the palette: loads are ignored, converts read black
    function automatic logic index_in_range(input logic [IndexWidth-1:0] idx);
        index_in_range = ({1'b0, idx} < (IndexWidth + 1)'(PALETTE_ENTRIES));
    endfunction

    assign idx_hit = index_in_range(pix_in.src_pixel[IndexWidth-1:0]);

    fbpfc_palette #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_palette (
        .clk     (clk),
        .wr_en   (in_accept && is_load && index_in_range(pix_in.palette_index)),
        .wr_addr (pix_in.palette_index[AddrWidth-1:0]),
        .wr_data (pix_in.palette_color),
        .rd_en   (in_accept && !is_load),
        .rd_addr (pix_in.src_pixel[AddrWidth-1:0]),
        .rd_data (pal_rd_data)
    );

    // palette stage: only convert words with a known destination format advance
    assign pal_valid_next = pix_in.ready ? (in_accept && !is_load && dest_ok) : pal_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_valid_reg <= 1'b0;
        end
        else
        begin
            pal_valid_reg <= pal_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && !is_load)
        begin
            pal_src_reg <= pix_in.src_pixel[23:0];
            pal_hit_reg <= idx_hit;
        end
    end

    fbpfc_convert u_convert (
        .cfg       (cfg_reg),
        .src       (pal_src_reg),
        .pal_color (pal_rd_data),
        .pal_hit   (pal_hit_reg),
        .pixel     (conv_pixel)
    );

    // output register
    assign out_valid_next = pal_adv ? pal_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pal_adv && pal_valid_reg)
        begin
            out_pixel_reg <= conv_pixel;
        end
    end

    assign pix_out.valid = out_valid_reg;
    assign pix_out.out_pixel = out_pixel_reg;

    `FBPFC_ASSERT_IMP(a_load_no_result, clk, rst_n, in_accept && is_load, !pal_valid_reg, "palette load entered the pixel stage")
    `FBPFC_ASSERT_IMP(a_bad_dest_no_result, clk, rst_n, in_accept && !is_load && !dest_ok, !pal_valid_reg, "convert with unknown format entered the pixel stage")
    `FBPFC_ASSERT(a_ready_only_on_full, clk, rst_n, !pix_in.ready |-> (pal_valid_reg && out_valid_reg && !pix_out.ready), "input stalled without a full pipeline")
    `FBPFC_ASSERT_IMP(a_stage_moves_out, clk, rst_n, pal_valid_reg && pal_adv, out_valid_reg, "pixel stage word lost on advance")

endmodule

// ----- rtl/fbpfc_palette.sv -----
`timescale 1ns / 1ps
module fbpfc_palette
    import fbpfc_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PaletteEntriesDefault,
    localparam int AddrWidth = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [AddrWidth-1:0]  wr_addr,
    input  logic [ColorWidth-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [AddrWidth-1:0]  rd_addr,
    output logic [ColorWidth-1:0] rd_data
);

    logic [ColorWidth-1:0] mem [PALETTE_ENTRIES];
    logic [ColorWidth-1:0] rd_data_reg;

    // single write port, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/fbpfc_convert.sv -----
`timescale 1ns / 1ps
module fbpfc_convert
    import fbpfc_pkg::*;
(
    input  cfg_t                  cfg,
    input  logic [23:0]           src,
    input  logic [ColorWidth-1:0] pal_color,
    input  logic                  pal_hit,
    output logic [PixelWidth-1:0] pixel
);

    logic [7:0] r_exp;
    logic [7:0] g_exp;
    logic [7:0] b_exp;
    logic [7:0] r_ord;
    logic [7:0] b_ord;

    // expand source to 8-bit channels
    always_comb
    begin
        r_exp = '0;
        g_exp = '0;
        b_exp = '0;
        unique case (cfg.source_depth)
            SRC_PAL8:
            begin
                if (pal_hit)
                begin
                    r_exp = pal_color[7:0];
                    g_exp = pal_color[15:8];
                    b_exp = pal_color[23:16];
                end
            end
            SRC_RGB565:
            begin
                r_exp = {src[15:11], 3'b000};
                g_exp = {src[10:5], 2'b00};
                b_exp = {src[4:0], 3'b000};
            end
            SRC_RGB24, SRC_RGB32:
            begin
                r_exp = src[7:0];
                g_exp = src[15:8];
                b_exp = src[23:16];
            end
            default:
            begin
                r_exp = '0;
            end
        endcase
    end

    // swap red and blue for BGR
    assign r_ord = cfg.rgb_order ? r_exp : b_exp;
    assign b_ord = cfg.rgb_order ? b_exp : r_exp;

    always_comb
    begin
        unique case (cfg.dest_format)
            DST_8BPP:            pixel = {16'd0, r_ord[7:5], g_exp[7:5], b_ord[7:6]};
            DST_15BPP:           pixel = {9'd0, r_ord[7:3], g_exp[7:3], b_ord[7:3]};
            DST_16BPP:           pixel = {8'd0, r_ord[7:3], g_exp[7:2], b_ord[7:3]};
            DST_24BPP, DST_32BPP: pixel = {r_ord, g_exp, b_ord};
            default:             pixel = '0;
        endcase
    end

endmodule

// ----- dv/fbpfc_pixel_checker.sv -----
`timescale 1ns / 1ps
module fbpfc_pixel_checker
    import fbpfc_pkg::*;
#(
    parameter int PAL_ENTRIES = PaletteEntriesDefault
) (
    input  logic                     clk,
    input  logic                     rst_n,
    fbpfc_in_if                      pix_in,
    fbpfc_out_if                     pix_out,
    input  logic                     cfg_we,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_wdata,
    output int                       fail_count,
    output int                       pending
);

    // shadow copy of the block's registers and palette
    logic [2:0]            shadow_depth;
    logic                  shadow_order;
    logic [2:0]            shadow_dest;
    logic [ColorWidth-1:0] shadow_palette [0:255];

    logic [PixelWidth-1:0] expected_pixels [$];

    // expand, swap and pack one source pixel; drop it when the format writes nothing
    function automatic logic [PixelWidth-1:0] convert_pixel(input logic [SrcWidth-1:0] src,
                                                             output bit emits);
        logic [7:0]            r;
        logic [7:0]            g;
        logic [7:0]            b;
        logic [7:0]            tmp;
        logic [ColorWidth-1:0] entry;
        logic [PixelWidth-1:0] pix;
        r = 8'h00;
        g = 8'h00;
        b = 8'h00;
        pix = '0;
        emits = 1'b1;
        case (shadow_depth)
            SRC_PAL8:
            begin
                entry = (int'(src[7:0]) < PAL_ENTRIES) ? shadow_palette[src[7:0]] : '0;
                r = entry[7:0];
                g = entry[15:8];
                b = entry[23:16];
            end
            SRC_RGB565:
            begin
                r = {src[15:11], 3'b000};
                g = {src[10:5], 2'b00};
                b = {src[4:0], 3'b000};
            end
            SRC_RGB24, SRC_RGB32:
            begin
                r = src[7:0];
                g = src[15:8];
                b = src[23:16];
            end
            default:
            begin
                r = 8'h00;
            end
        endcase
        if (!shadow_order)
        begin
            tmp = r;
            r = b;
            b = tmp;
        end
        case (shadow_dest)
            DST_8BPP:             pix = {16'h0000, r[7:5], g[7:5], b[7:6]};
            DST_15BPP:            pix = {9'h000, r[7:3], g[7:3], b[7:3]};
            DST_16BPP:            pix = {8'h00, r[7:3], g[7:2], b[7:3]};
            DST_24BPP, DST_32BPP: pix = {r, g, b};
            default:              emits = 1'b0;
        endcase
        return pix;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [PixelWidth-1:0] want;
        logic [PixelWidth-1:0] got;
        bit                    emits;
        if (!rst_n)
        begin
            shadow_depth = SRC_RGB565;
            shadow_order = 1'b1;
            shadow_dest  = DST_32BPP;
            expected_pixels.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SOURCE_DEPTH: shadow_depth = cfg_wdata;
                    CFG_RGB_ORDER:    shadow_order = cfg_wdata[0];
                    CFG_DEST_FORMAT:  shadow_dest = cfg_wdata;
                    default:          ;
                endcase
            end
            // compare first: a word leaving now belongs to an older item
            if (pix_out.valid && pix_out.ready)
            begin
                got = pix_out.out_pixel;
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: out_pixel expected none, got %06h", $time, got);
                    fail_count++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: out_pixel expected %06h, got %06h", $time, want, got);
                        fail_count++;
                    end
                end
            end
            if (pix_in.valid && pix_in.ready)
            begin
                if (pix_in.op == OP_LOAD)
                begin
                    if (int'(pix_in.palette_index) < PAL_ENTRIES)
                        shadow_palette[pix_in.palette_index] = pix_in.palette_color;
                end
                else
                begin
                    want = convert_pixel(pix_in.src_pixel, emits);
                    if (emits)
                        expected_pixels.push_back(want);
                end
            end
            pending = expected_pixels.size();
        end
    end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
module tb
    import fbpfc_pkg::*;
();

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 1000;
    // the last stretch of the random part runs with no idling at all
    localparam int CALM_AFTER   = 850;
    // two pipeline stages, plus slack, before the config port may be touched
    localparam int DRAIN_CYCLES = 4;
    localparam int TAIL_CYCLES  = 8;
    // index with no register behind it; writes there must change nothing
    localparam logic [CfgIndexWidth-1:0] CFG_UNUSED = 2'd3;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CfgIndexWidth-1:0] cfg_index;
    logic [CfgDataWidth-1:0]  cfg_wdata;
    int                       fail_count;
    int                       pending;
    int                       cycles = 0;

    // stimulus state
    logic [2:0] cur_depth;
    bit         calm;
    int         in_idle_pct;
    int         out_idle_pct;
    int         load_pct;
    int         ready_hold = 0;
    bit         pal_loaded [0:255];
    int         loaded_idx [$];

    fbpfc_in_if  pix_in ();
    fbpfc_out_if pix_out ();

    framebuffer_pixel_format_converter_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_in    (pix_in),
        .pix_out   (pix_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    fbpfc_pixel_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_in     (pix_in),
        .pix_out    (pix_out),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // hard stop in case a word never gets through
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[framebuffer_pixel_format_converter_core] ERROR");
            $finish;
        end
    end

    // Display side: drop ready in bursts of random length; no new burst starts once calm.
    always @(negedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
            pix_out.ready <= 1'b0;
        end
        else if (!calm && $urandom_range(99) < out_idle_pct)
        begin
            ready_hold <= $urandom_range(16);
            pix_out.ready <= 1'b0;
        end
        else
        begin
            pix_out.ready <= 1'b1;
        end
    end

    function automatic int pick_gap();
        if (calm || $urandom_range(99) >= in_idle_pct)
            return 0;
        return $urandom_range(17, 1);
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(3))
            0:       return 0;
            1:       return 10;
            2:       return 30;
            default: return 60;
        endcase
    endfunction

    // Present one word, optionally after an idle gap, and hold it until accepted.
    // Entered and left at a falling edge; valid stays high for a following word.
    task automatic send_word(input op_t op, input logic [SrcWidth-1:0] src,
                             input logic [IndexWidth-1:0] idx,
                             input logic [ColorWidth-1:0] col);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            pix_in.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_in.valid         <= 1'b1;
        pix_in.op            <= op;
        pix_in.src_pixel     <= src;
        pix_in.palette_index <= idx;
        pix_in.palette_color <= col;
        // remember loaded entries so palette converts only hit written ones
        if (op == OP_LOAD && !pal_loaded[idx])
        begin
            pal_loaded[idx] = 1'b1;
            loaded_idx.push_back(int'(idx));
        end
        @(posedge clk);
        while (!pix_in.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_convert(input logic [SrcWidth-1:0] src);
        send_word(OP_CONVERT, src, IndexWidth'($urandom_range(255)),
                  ColorWidth'($urandom_range(24'hFFFFFF)));
    endtask

    task automatic send_load(input logic [IndexWidth-1:0] idx, input logic [ColorWidth-1:0] col);
        send_word(OP_LOAD, $urandom, idx, col);
    endtask

    // Drop valid, wait for every expected pixel, then let the pipeline run dry.
    task automatic settle();
        pix_in.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
                             input logic [CfgDataWidth-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
    endtask

    // Reprogram all three registers on an idle block; optionally poke the spare index.
    task automatic set_format(input logic [2:0] depth, input logic [2:0] order,
                              input logic [2:0] dest, input bit poke_unused);
        settle();
        write_reg(CFG_SOURCE_DEPTH, depth);
        if (poke_unused)
            write_reg(CFG_UNUSED, CfgDataWidth'($urandom_range(7)));
        write_reg(CFG_RGB_ORDER, order);
        write_reg(CFG_DEST_FORMAT, dest);
        cfg_we <= 1'b0;
        cur_depth = depth;
    endtask

    // One random word: mostly converts, loads mixed in; palette converts
    // pick an index that has already been loaded.
    task automatic random_word();
        op_t                   op;
        logic [SrcWidth-1:0]   src;
        logic [IndexWidth-1:0] idx;
        logic [ColorWidth-1:0] col;
        op  = ($urandom_range(99) < load_pct) ? OP_LOAD : OP_CONVERT;
        src = $urandom;
        idx = IndexWidth'($urandom_range(255));
        col = ColorWidth'($urandom_range(24'hFFFFFF));
        // now and then an all-zeros or all-ones source
        if ($urandom_range(15) == 0)
            src = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        if (op == OP_CONVERT && cur_depth == SRC_PAL8)
        begin
            if (loaded_idx.size() == 0)
                op = OP_LOAD;
            else
                src[7:0] = 8'(loaded_idx[$urandom_range(loaded_idx.size() - 1)]);
        end
        send_word(op, src, idx, col);
    endtask

    initial
    begin
        int         sent;
        int         words;
        logic [2:0] depth;
        logic [2:0] order;
        logic [2:0] dest;

        // every input known from time zero
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_wdata            = '0;
        pix_in.valid         = 1'b0;
        pix_in.op            = OP_CONVERT;
        pix_in.src_pixel     = '0;
        pix_in.palette_index = '0;
        pix_in.palette_color = '0;
        pix_out.ready        = 1'b0;
        cur_depth            = SRC_RGB565;
        calm                 = 1'b0;
        in_idle_pct          = 0;
        out_idle_pct         = 0;
        load_pct             = 15;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part, back to back. Reset config first: RGB565 in, RGB order, 32 bpp out.
        send_convert(32'h0000_0000);
        send_convert(32'hFFFF_FFFF);      // upper half must be ignored
        send_convert(32'h1234_F800);      // red only
        send_convert(32'h0000_07E0);      // green only
        send_convert(32'h0000_001F);      // blue only
        send_load(8'h00, 24'h000000);
        send_load(8'hFF, 24'hFFFFFF);
        send_load(8'h5A, 24'h123456);
        send_load(8'hA5, 24'hFEDCBA);

        // palette source, swapped order, 3-3-2 packing
        set_format(SRC_PAL8, 3'd0, DST_8BPP, 1'b1);
        send_convert(32'hFFFF_FF00);
        send_convert(32'h0000_00FF);
        send_convert(32'h8000_005A);
        send_convert(32'h0000_00A5);
        // reload right before a read, then read right before a reload
        send_load(8'hFF, 24'h00FF00);
        send_convert(32'h0000_00FF);
        send_convert(32'h0000_005A);
        send_load(8'h5A, 24'h0F0F0F);
        send_convert(32'h0000_005A);

        set_format(SRC_RGB24, 3'd1, DST_24BPP, 1'b0);
        send_convert(32'hFFFF_FFFF);
        send_convert(32'h00A1_B2C3);
        set_format(SRC_RGB32, 3'd6, DST_15BPP, 1'b0);    // order written with upper bits set
        send_convert(32'hDEAD_BEEF);
        set_format(SRC_NONE, 3'd1, DST_16BPP, 1'b0);     // unsupported source: black
        send_convert(32'hFFFF_FFFF);
        set_format(3'd7, 3'd0, DST_32BPP, 1'b0);         // reserved source depth: black
        send_convert(32'h5555_AAAA);
        set_format(SRC_RGB565, 3'd1, 3'd7, 1'b0);        // reserved formats write nothing
        send_convert(32'hFFFF_FFFF);
        set_format(SRC_RGB565, 3'd1, 3'd5, 1'b1);
        send_convert(32'h0000_1234);

        // Random part: phases of random config, idling and content.
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            calm = (sent >= CALM_AFTER);
            depth = ($urandom_range(9) < 3) ? SRC_PAL8 : 3'($urandom_range(1, 7));
            order = 3'($urandom_range(7));
            dest  = ($urandom_range(9) < 8) ? 3'($urandom_range(4)) : 3'($urandom_range(5, 7));
            set_format(depth, order, dest, $urandom_range(7) == 0);
            in_idle_pct  = pick_idle_pct();
            out_idle_pct = pick_idle_pct();
            load_pct     = (depth == SRC_PAL8) ? 25 : 15;
            words        = $urandom_range(40, 100);
            for (int i = 0; i < words && sent < RANDOM_WORDS; i++)
            begin
                random_word();
                sent++;
            end
        end

        // drain, let the tail run out, then give the verdict
        pix_in.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[framebuffer_pixel_format_converter_core] OK");
        else
            $display("[framebuffer_pixel_format_converter_core] ERROR");
        $finish;
    end

endmodule
